FILE: src/vls_pkg.sv
// Shared types, constants and register codes for the VGA line sequencer.
// No dependencies; every other file in src imports this package.
package vls_pkg;

    // Field widths
    localparam int LINE_W   = 12;
    localparam int PIX_W    = 12;
    localparam int PERIOD_W = 8;
    localparam int SAV_W    = 13;
    localparam int COUNT_W  = 12;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Stream widths
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 48;

    // Longest line buffer, in pixels
    localparam logic [PIX_W-1:0] MAX_LINE_PIXELS = 12'd2200;

    // Pixel period above which a timer paces the transfer
    localparam logic [PERIOD_W-1:0] TIMER_PERIOD_MIN = 8'd4;

    // Frame phase bits
    localparam int DISPLAYED_BIT = 1;
    localparam int RENDERED_BIT  = 0;

    // Register reset values
    localparam logic [LINE_W-1:0] RST_VSYNC_START = 12'd490;
    localparam logic [LINE_W-1:0] RST_VSYNC_END   = 12'd492;
    localparam logic [LINE_W-1:0] RST_VIDEO_START = 12'd45;
    localparam logic [LINE_W-1:0] RST_VIDEO_END   = 12'd525;
    localparam logic [LINE_W-1:0] RST_SAV_BASE    = 12'd144;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VSYNC_START = 3'd0,
        REG_VSYNC_END   = 3'd1,
        REG_VIDEO_START = 3'd2,
        REG_VIDEO_END   = 3'd3,
        REG_SAV_BASE    = 3'd4,
        REG_VSYNC_NEG   = 3'd5
    } t_cfg_idx;

    // Gray-coded frame phase
    typedef enum logic [1:0] {
        PH_BLANK     = 2'b00,
        PH_STARTING  = 2'b01,
        PH_ACTIVE    = 2'b11,
        PH_FINISHING = 2'b10
    } t_phase;

    // DMA transfer unit
    typedef enum logic [1:0] {
        XU_BYTE = 2'd0,
        XU_HALF = 2'd1,
        XU_WORD = 2'd2
    } t_xfer_unit;

    // Configuration register set
    typedef struct packed {
        logic [LINE_W-1:0] vs_first_line;
        logic [LINE_W-1:0] vs_last_line;
        logic [LINE_W-1:0] act_first_line;
        logic [LINE_W-1:0] frame_lines;
        logic [LINE_W-1:0] sav_base;
        logic              vsync_negative;
    } t_cfg;

    // Vertical timing result of one event
    typedef struct packed {
        logic [LINE_W-1:0] line_number;
        t_phase            frame_state;
        logic              vs_level;
        logic              band_take;
        logic              vert_blank;
    } t_line_res;

    // DMA set-up result of one event
    typedef struct packed {
        t_xfer_unit         transfer_unit;
        logic [COUNT_W-1:0] transfer_count;
        logic               use_pixel_timer;
    } t_xfer_res;

endpackage

FILE: src/vls_cfg_regs.sv
// Configuration register file of the VGA line sequencer.
// Depends on vls_pkg for register codes, reset values and the t_cfg struct.
module vls_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [vls_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vls_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output vls_pkg::t_cfg                  o_cfg
);
    import vls_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write; unknown indexes leave the set unchanged
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_VSYNC_START: n_cfg.vs_first_line  = i_cfg_data;
                REG_VSYNC_END:   n_cfg.vs_last_line   = i_cfg_data;
                REG_VIDEO_START: n_cfg.act_first_line = i_cfg_data;
                REG_VIDEO_END:   n_cfg.frame_lines    = i_cfg_data;
                REG_SAV_BASE:    n_cfg.sav_base       = i_cfg_data;
                REG_VSYNC_NEG:   n_cfg.vsync_negative = i_cfg_data[0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    // Hold the registers, load reset values on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vs_first_line  <= RST_VSYNC_START;
            r_cfg.vs_last_line   <= RST_VSYNC_END;
            r_cfg.act_first_line <= RST_VIDEO_START;
            r_cfg.frame_lines    <= RST_VIDEO_END;
            r_cfg.sav_base       <= RST_SAV_BASE;
            r_cfg.vsync_negative <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/vls_timing.sv
// Vertical timing state: line counter, vsync level and Gray-coded frame phase.
// Depends on vls_pkg for t_cfg, t_phase and t_line_res.
module vls_timing (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  vls_pkg::t_cfg      i_cfg,
    output vls_pkg::t_line_res o_res
);
    import vls_pkg::*;

    logic [LINE_W-1:0] r_line;
    logic [LINE_W-1:0] n_line;
    t_phase            r_phase;
    t_phase            n_phase;
    logic              r_vsync;
    logic              n_vsync;
    logic              n_take;

    logic [LINE_W-1:0] w_step;
    logic              w_vs_hit;
    logic              w_start_m1;
    logic              w_start_hit;
    logic              w_end_m1;
    logic              w_end_hit;

    // Line compares against the incremented counter
    assign w_step      = r_line + 1'b1;
    assign w_vs_hit    = (w_step == i_cfg.vs_first_line) ||
                         (w_step == i_cfg.vs_last_line);
    assign w_start_m1  = (i_cfg.act_first_line != '0) &&
                         (w_step == i_cfg.act_first_line - 1'b1);
    assign w_start_hit = (w_step == i_cfg.act_first_line);
    assign w_end_m1    = (i_cfg.frame_lines != '0) &&
                         (w_step == i_cfg.frame_lines - 1'b1);
    assign w_end_hit   = (w_step == i_cfg.frame_lines);

    // Next state: vsync first, then the phase tests in priority order
    always_comb begin
        n_line  = w_step;
        n_phase = r_phase;
        n_vsync = r_vsync;
        if (w_vs_hit) begin
            n_vsync = ~r_vsync;
        end else if (w_start_m1) begin
            n_phase = PH_STARTING;
        end else if (w_start_hit) begin
            n_phase = PH_ACTIVE;
        end else if (w_end_m1) begin
            n_phase = PH_FINISHING;
        end else if (w_end_hit) begin
            n_phase = PH_BLANK;
            n_line  = '0;
        end
    end

    // Outputs: the state after this event
    always_comb begin
        n_take            = !w_vs_hit && w_start_m1;
        o_res.line_number = n_line;
        o_res.frame_state = n_phase;
        o_res.vs_level    = n_vsync ^ i_cfg.vsync_negative;
        o_res.band_take   = n_take;
        o_res.vert_blank  = (n_line < i_cfg.act_first_line);
    end

    // Advance the state once per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line  <= '0;
            r_phase <= PH_BLANK;
            r_vsync <= 1'b0;
        end else if (i_advance) begin
            r_line  <= n_line;
            r_phase <= n_phase;
            r_vsync <= n_vsync;
        end
    end

endmodule

FILE: src/vls_xfer.sv
// DMA set-up for one line buffer: transfer unit, item count and timer pacing.
// Depends on vls_pkg for widths, limits and t_xfer_res.
module vls_xfer (
    input  logic [vls_pkg::PIX_W-1:0]    i_line_length,
    input  logic [vls_pkg::PERIOD_W-1:0] i_pixel_period,
    input  logic                         i_displayed,
    output vls_pkg::t_xfer_res           o_res
);
    import vls_pkg::*;

    logic [PIX_W-1:0]   w_len;
    t_xfer_unit         w_unit;
    logic               w_timer;
    logic [COUNT_W:0]   w_count;
    logic [COUNT_W-1:0] w_count_sat;

    // Clamp the length and pick the widest unit it divides into
    always_comb begin
        w_len = (i_line_length > MAX_LINE_PIXELS) ? MAX_LINE_PIXELS : i_line_length;
        case (w_len[1:0])
            2'd0:    w_unit = XU_WORD;
            2'd2:    w_unit = XU_HALF;
            default: w_unit = XU_BYTE;
        endcase
        w_timer = (i_pixel_period > TIMER_PERIOD_MIN);
    end

    // Count bytes plus one unit when timer-paced, else units plus one; saturate
    always_comb begin
        if (w_timer) begin
            case (w_unit)
                XU_WORD: w_count = {1'b0, w_len} + (COUNT_W+1)'(4);
                XU_HALF: w_count = {1'b0, w_len} + (COUNT_W+1)'(2);
                default: w_count = {1'b0, w_len} + (COUNT_W+1)'(1);
            endcase
        end else begin
            case (w_unit)
                XU_WORD: w_count = {3'b000, w_len[PIX_W-1:2]} + (COUNT_W+1)'(1);
                XU_HALF: w_count = {2'b00, w_len[PIX_W-1:1]} + (COUNT_W+1)'(1);
                default: w_count = {1'b0, w_len} + (COUNT_W+1)'(1);
            endcase
        end
        w_count_sat = w_count[COUNT_W] ? {COUNT_W{1'b1}} : w_count[COUNT_W-1:0];
    end

    // Drop everything while the line is not displayed
    always_comb begin
        if (i_displayed) begin
            o_res.transfer_unit   = w_unit;
            o_res.transfer_count  = w_count_sat;
            o_res.use_pixel_timer = w_timer;
        end else begin
            o_res.transfer_unit   = XU_BYTE;
            o_res.transfer_count  = '0;
            o_res.use_pixel_timer = 1'b0;
        end
    end

endmodule

FILE: src/vga_line_sequencer.sv
// VGA line sequencer: one end-of-active-video transaction in, one line result out.
// Registered through an input register, then a result register; throughput 1 per cycle
// while the result stream is not stalled, updating line counter, vsync and phase.
// Synchronous active-low reset clears line counter, phase (blank), vsync and both
// valid flags, and loads the configuration reset values.
// Depends on vls_pkg, vls_cfg_regs, vls_timing and vls_xfer.
module vga_line_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port
    input  logic                           i_cfg_we,
    input  logic [vls_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vls_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Event stream in
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: line_offset[11:0], line_length[23:12], pixel_period[31:24]
    input  logic [vls_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // Result stream out
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: line_number[11:0], frame_state[13:12], vs_level[14], band_take[15],
    // vert_blank[16], displayed[17], rendered[18], sav_compare[31:19],
    // transfer_unit[33:32], transfer_count[45:34], use_pixel_timer[46], zero[47]
    output logic [vls_pkg::M_DATA_W-1:0]   m_axis_tdata
);
    import vls_pkg::*;

    t_cfg      w_cfg;
    t_line_res w_line;
    t_xfer_res w_xfer;

    logic                  r_in_valid;
    logic [S_DATA_W-1:0]   r_in_data;
    logic                  r_out_valid;
    logic [M_DATA_W-1:0]   r_out_data;

    logic                  w_in_accept;
    logic                  w_advance;
    logic [PIX_W-1:0]      w_offset;
    logic [PIX_W-1:0]      w_length;
    logic [PERIOD_W-1:0]   w_period;
    logic [SAV_W-1:0]      w_sav;
    logic                  w_displayed;
    logic [M_DATA_W-1:0]   n_out_data;

    // Handshake: move a transaction when the result register is free or draining
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;

    // Unpack the held input transaction
    assign w_offset = r_in_data[PIX_W-1:0];
    assign w_length = r_in_data[2*PIX_W-1:PIX_W];
    assign w_period = r_in_data[2*PIX_W+PERIOD_W-1:2*PIX_W];

    vls_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    vls_timing u_timing (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_cfg     (w_cfg),
        .o_res     (w_line)
    );

    assign w_displayed = w_line.frame_state[DISPLAYED_BIT];

    vls_xfer u_xfer (
        .i_line_length  (w_length),
        .i_pixel_period (w_period),
        .i_displayed    (w_displayed),
        .o_res          (w_xfer)
    );

    // Start-of-video compare
    assign w_sav = {1'b0, w_cfg.sav_base} + {1'b0, w_offset};

    // Pack the result transaction
    assign n_out_data = {
        1'b0,
        w_xfer.use_pixel_timer,
        w_xfer.transfer_count,
        w_xfer.transfer_unit,
        w_sav,
        w_line.frame_state[RENDERED_BIT],
        w_line.frame_state[DISPLAYED_BIT],
        w_line.vert_blank,
        w_line.band_take,
        w_line.vs_level,
        w_line.frame_state,
        w_line.line_number
    };

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_data <= s_axis_tdata;
        end
        if (w_advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
